// ===== src/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  // Default number of slots in the queue.
  localparam int unsigned DepthDefault = 8;

  // Field widths fixed by the interface.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CmdPushFront = 3'd0,
    CmdPushBack  = 3'd1,
    CmdPopFront  = 3'd2,
    CmdPopBack   = 3'd3,
    CmdSearch    = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StatOk       = 2'd0,
    StatNoRoom   = 2'd1,
    StatEmpty    = 2'd2,
    StatNotFound = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // a transaction is taken this cycle
    logic load_scan;  // start a search at the front slot
    logic read;       // read the slot under the scan pointer
    logic finish;     // the search ends with this compare
    logic advance;    // move the scan pointer to the next slot
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_go;  // the offered command is a search on a non-empty queue
    logic hit;        // the slot just read matches the key
    logic last;       // the scan pointer sits at the back slot
  } stat_t;

endpackage

`default_nettype wire

// ===== src/bdq_ctrl.sv =====
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StCmp  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.accept = 1'b1;
          if (stat_i.search_go) begin
            ctrl_o.load_scan = 1'b1;
            state_d          = StRead;
          end
        end
      end
      StRead: begin
        ctrl_o.read = 1'b1;
        state_d     = StCmp;
      end
      StCmp: begin
        if (stat_i.hit || stat_i.last) begin
          ctrl_o.finish = 1'b1;
          state_d       = StIdle;
        end else begin
          ctrl_o.advance = 1'b1;
          state_d        = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bdq_dp.sv =====
`default_nettype none

module bdq_dp
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctrl_t                    ctrl_i,
  input  wire logic [CmdW-1:0]          cmd_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output stat_t                         stat_o,
  output logic                          done_o,
  output logic [StatusW-1:0]            status_o,
  output logic [IdxW-1:0]               slot_index_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  // Slot storage, written by pushes and read by the search scan.
  logic [ValueW-1:0] mem [DEPTH];

  logic [IdxW-1:0]   front_q, front_d;
  logic [IdxW-1:0]   back_q, back_d;
  logic              empty_q, empty_d;
  logic [IdxW-1:0]   scan_q;
  logic [ValueW-1:0] key_q;
  logic [ValueW-1:0] rd_q;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;

  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [IdxW-1:0]   slot_q, slot_d;

  // Status toward the controller.
  assign stat_o.search_go = (cmd_e'(cmd_i) == CmdSearch) && !empty_q;
  assign stat_o.hit       = (rd_q == key_q);
  assign stat_o.last      = (scan_q == back_q);

  // Queue update and result for every command that completes at once, and the search result when the scan finishes.
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    empty_d  = empty_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    done_d   = 1'b0;
    status_d = StatOk;
    slot_d   = '0;

    if (ctrl_i.accept) begin
      done_d = 1'b1;
      case (cmd_e'(cmd_i))
        CmdPushFront: begin
          if (empty_q || front_q == '0) begin
            status_d = StatNoRoom;
          end else begin
            front_d = front_q - 1'b1;
            wr_en   = 1'b1;
            wr_addr = front_q - 1'b1;
            slot_d  = front_q - 1'b1;
          end
        end
        CmdPushBack: begin
          if (empty_q) begin
            front_d = '0;
            back_d  = '0;
            empty_d = 1'b0;
            wr_en   = 1'b1;
            wr_addr = '0;
          end else if (back_q == LastIdx) begin
            status_d = StatNoRoom;
          end else begin
            back_d  = back_q + 1'b1;
            wr_en   = 1'b1;
            wr_addr = back_q + 1'b1;
            slot_d  = back_q + 1'b1;
          end
        end
        CmdPopFront, CmdPopBack: begin
          if (empty_q) begin
            status_d = StatEmpty;
          end else if (front_q == back_q) begin
            front_d = '0;
            back_d  = '0;
            empty_d = 1'b1;
          end else if (cmd_e'(cmd_i) == CmdPopFront) begin
            front_d = front_q + 1'b1;
          end else begin
            back_d = back_q - 1'b1;
          end
        end
        CmdSearch: begin
          if (empty_q) begin
            status_d = StatEmpty;
          end else begin
            // The scan delivers the result later.
            done_d = 1'b0;
          end
        end
        default: begin
          status_d = StatOk;
        end
      endcase
    end else if (ctrl_i.finish) begin
      done_d = 1'b1;
      if (stat_o.hit) begin
        status_d = StatOk;
        slot_d   = scan_q;
      end else begin
        status_d = StatNotFound;
      end
    end
  end

  // Control registers: queue bounds and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      empty_q <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      empty_q <= empty_d;
      done_q  <= done_d;
    end
  end

  // Result payload and scan registers.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
    if (ctrl_i.load_scan) begin
      scan_q <= front_q;
      key_q  <= value_i;
    end else if (ctrl_i.advance) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    if (ctrl_i.read) begin
      rd_q <= mem[scan_q];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;

endmodule

`default_nettype wire

// ===== src/bounded_deque_with_search.sv =====
`default_nettype none

// Bounded double-ended queue in a fixed, non-circular array, with search.
// Command channel: cmd_i and value_i are taken at a rising edge where start
// is high and busy is low. Commands are push front, push back, pop front,
// pop back and search; each transaction yields exactly one result.
// Result channel: status_o and slot_index_o are valid for the single cycle
// in which done_o is high; the receiver cannot stall the block.
// Push, pop, unused codes and a search of an empty queue: done_o rises in the
// cycle after acceptance and busy stays low, so one transaction per cycle.
// Search of a non-empty queue: busy is high while the scan runs, and done_o
// rises after the last compare; 1 to DEPTH slots are compared. Each compare
// is a registered read of the slot memory read port followed by the key
// compare.
// Reset clears both indices, marks the queue empty and drops any search in
// progress; slot contents are not cleared and need no clearing pass.

module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CmdW-1:0]          cmd_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          done_o,
  output logic [StatusW-1:0]            status_o,
  output logic [IdxW-1:0]               slot_index_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer for command acceptance and the search scan.
  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // Queue state, slot memory and result registers.
  bdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_index_o(slot_index_o)
  );

endmodule

`default_nettype wire
